@@ hw/rtl/bffa_pkg.sv @@
// Shared constants, codes and helper functions for the first-fit bitmap allocator.
`default_nettype none

package bffa_pkg;

	// Pool geometry
	localparam int ENTRIES       = 1024;
	localparam int BITS_PER_BYTE = 8;
	localparam int STORE_BYTES   = ENTRIES / BITS_PER_BYTE;
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int SPAN_W        = $clog2(STORE_BYTES + 1);
	localparam int BIT_W         = $clog2(BITS_PER_BYTE);
	localparam int ZCNT_W        = $clog2(BITS_PER_BYTE + 1);

	// Field widths
	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 11;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 11;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 32;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int CFG_W   = 8;
	localparam logic [PADDR_W-3:0] CFG_BYTES_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0]   CFG_RESET        = 8'd128;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TAKE  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TAKEN = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

	// Number of clear bits in one bitmap byte
	function automatic logic [ZCNT_W-1:0] zero_count(input logic [BITS_PER_BYTE-1:0] b);
		logic [ZCNT_W-1:0] c;
		c = '0;
		for (int k = 0; k < BITS_PER_BYTE; k++) begin
			if (!b[k]) begin
				c = c + ZCNT_W'(1);
			end
		end
		return c;
	endfunction

	// Position of the lowest clear bit; only meaningful when one exists
	function automatic logic [BIT_W-1:0] first_zero(input logic [BITS_PER_BYTE-1:0] b);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int k = BITS_PER_BYTE - 1; k >= 0; k--) begin
			if (!b[k]) begin
				pos = BIT_W'(k);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bitmap_first_free_allocator.sv @@
// First-fit bitmap allocator: free-entry bitmap in a synchronous RAM, scan and RMW.
// Scan: each item reads span bytes of the bitmap, where span is
//   min(bytes_in_use, 128); the RAM read port scans every in-range byte once per item.
// Items: one item in flight; the EXEC step holds while the output register is full, and the
//   next input is taken while the previous result still sits in the output register.
// Reset: bitmap reads as all free through per-byte valid flops, no clearing pass;
//   bytes_in_use resets to 128.
`default_nettype none

module bitmap_first_free_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [bffa_pkg::IN_W-1:0]     s_tdata,   // func[1:0], entry_index[12:2], zero pad
	// result stream
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [bffa_pkg::OUT_W-1:0]    m_tdata,   // entry_number[10:0], status[13:11],
	                                                      // free_count[24:14], zero pad
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bffa_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [bffa_pkg::PDATA_W-1:0]  pwdata,
	output      logic [bffa_pkg::PDATA_W-1:0]  prdata,
	output      logic                          pready
);

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	localparam int AW = bffa_pkg::ADDR_W;
	localparam int BW = bffa_pkg::BITS_PER_BYTE;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [bffa_pkg::CFG_W-1:0] bytes_in_use_q;
	logic                       cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[bffa_pkg::PADDR_W-1:2] == bffa_pkg::CFG_BYTES_IN_USE);
	assign prdata  = cfg_sel ? bffa_pkg::PDATA_W'(bytes_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_in_use_q <= bffa_pkg::CFG_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			bytes_in_use_q <= pwdata[bffa_pkg::CFG_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Control and datapath registers
	// ------------------------------------------------------------------
	logic [1:0]                         state_q;
	logic [bffa_pkg::SPAN_W-1:0]        span_q;     // bytes scanned, clipped to the store
	logic [bffa_pkg::SPAN_W-1:0]        rd_cnt_q;   // next byte to read
	logic [bffa_pkg::FUNC_W-1:0]        func_q;
	logic [bffa_pkg::IDX_W-1:0]         idx_q;
	logic                               rd_vld_s1;
	logic [AW-1:0]                      rd_addr_s1;
	logic [BW-1:0]                      rd_data_s1;
	logic                               rd_init_s1; // byte was written since reset
	logic [bffa_pkg::CNT_W-1:0]         free_cnt_q;
	logic                               found_q;
	logic [AW-1:0]                      found_addr_q;
	logic [bffa_pkg::BIT_W-1:0]         found_bit_q;
	logic [BW-1:0]                      found_byte_q;
	logic [BW-1:0]                      tgt_byte_q;
	logic                               m_tvalid_q;
	logic [bffa_pkg::OUT_W-1:0]         m_tdata_q;

	// Bitmap RAM and its per-byte "written" flags (unwritten bytes read as free)
	logic [BW-1:0]                      mem_q [bffa_pkg::STORE_BYTES];
	logic [bffa_pkg::STORE_BYTES-1:0]   init_q;

	logic                               in_xact;
	logic                               out_free;
	logic                               exec_go;
	logic                               issue;
	logic [AW-1:0]                      rd_addr;
	logic [BW-1:0]                      rd_byte;
	logic [bffa_pkg::SPAN_W-1:0]        span_in;
	logic [bffa_pkg::IDX_W-1:0]         limit;
	logic                               in_range;
	logic [bffa_pkg::IDX_W-1:0]         idx_m1;
	logic [AW-1:0]                      tgt_addr;
	logic [bffa_pkg::BIT_W-1:0]         tgt_bit;
	logic [BW-1:0]                      tgt_mask;
	logic [bffa_pkg::IDX_W-1:0]         found_num;

	// Result and write-back of the EXEC step
	logic [bffa_pkg::IDX_W-1:0]         res_num;
	logic [bffa_pkg::STATUS_W-1:0]      res_status;
	logic [bffa_pkg::CNT_W-1:0]         res_free;
	logic                               wr_req;
	logic                               wr_en;
	logic [AW-1:0]                      wr_addr;
	logic [BW-1:0]                      wr_data;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xact  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign exec_go  = (state_q == ST_EXEC) && out_free;
	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < span_q);
	assign rd_addr  = rd_cnt_q[AW-1:0];
	assign rd_byte  = rd_init_s1 ? rd_data_s1 : '0;

	assign span_in  = (bytes_in_use_q > bffa_pkg::CFG_W'(bffa_pkg::STORE_BYTES))
	                  ? bffa_pkg::SPAN_W'(bffa_pkg::STORE_BYTES)
	                  : bffa_pkg::SPAN_W'(bytes_in_use_q);
	assign limit    = bffa_pkg::IDX_W'({span_q, {bffa_pkg::BIT_W{1'b0}}});
	assign in_range = (idx_q != '0) && (idx_q <= limit);
	assign idx_m1   = idx_q - bffa_pkg::IDX_W'(1);
	assign tgt_addr = idx_m1[AW+bffa_pkg::BIT_W-1:bffa_pkg::BIT_W];
	assign tgt_bit  = idx_m1[bffa_pkg::BIT_W-1:0];
	assign tgt_mask = BW'(1) << tgt_bit;
	assign found_num = bffa_pkg::IDX_W'({found_addr_q, found_bit_q}) + bffa_pkg::IDX_W'(1);

	// Sequencer: IDLE -> SCAN (one read per in-range byte) -> EXEC (decide, write back)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			free_cnt_q <= '0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			init_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						state_q    <= ST_SCAN;
						rd_cnt_q   <= '0;
						free_cnt_q <= '0;
						found_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + bffa_pkg::SPAN_W'(1);
					end else begin
						// last read data is folded in at this edge
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// output register: a new result may replace one leaving in the same cycle
			if (exec_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// fold in one scanned byte
			if (rd_vld_s1) begin
				free_cnt_q <= free_cnt_q + bffa_pkg::CNT_W'(bffa_pkg::zero_count(rd_byte));
				if (!found_q && (rd_byte != '1)) begin
					found_q <= 1'b1;
				end
			end
			if (wr_en) begin
				init_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_xact) begin
			span_q <= span_in;
			func_q <= s_tdata[bffa_pkg::FUNC_W-1:0];
			idx_q  <= s_tdata[bffa_pkg::FUNC_W+bffa_pkg::IDX_W-1:bffa_pkg::FUNC_W];
		end
		rd_addr_s1 <= rd_addr;
		rd_init_s1 <= init_q[rd_addr];
		if (rd_vld_s1 && !found_q && (rd_byte != '1)) begin
			found_addr_q <= rd_addr_s1;
			found_bit_q  <= bffa_pkg::first_zero(rd_byte);
			found_byte_q <= rd_byte;
		end
		if (rd_vld_s1 && (rd_addr_s1 == tgt_addr)) begin
			tgt_byte_q <= rd_byte;
		end
		if (exec_go) begin
			m_tdata_q <= bffa_pkg::OUT_W'({res_free, res_status, res_num});
		end
	end

	// Bitmap RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	// Decision for the current item
	always_comb begin
		res_num    = '0;
		res_status = bffa_pkg::ST_OK;
		res_free   = free_cnt_q;
		wr_req     = 1'b0;
		wr_addr    = found_addr_q;
		wr_data    = found_byte_q | (BW'(1) << found_bit_q);
		case (func_q)
			bffa_pkg::FUNC_ALLOC, bffa_pkg::FUNC_FIND: begin
				if (!found_q) begin
					res_status = bffa_pkg::ST_FULL;
				end else begin
					res_num = found_num;
					if (func_q == bffa_pkg::FUNC_ALLOC) begin
						wr_req   = 1'b1;
						res_free = free_cnt_q - bffa_pkg::CNT_W'(1);
					end
				end
			end
			bffa_pkg::FUNC_TAKE: begin
				wr_addr = tgt_addr;
				wr_data = tgt_byte_q | tgt_mask;
				if (!in_range) begin
					res_status = bffa_pkg::ST_RANGE;
				end else if ((tgt_byte_q & tgt_mask) != '0) begin
					res_num    = idx_q;
					res_status = bffa_pkg::ST_TAKEN;
				end else begin
					res_num  = idx_q;
					wr_req   = 1'b1;
					res_free = free_cnt_q - bffa_pkg::CNT_W'(1);
				end
			end
			bffa_pkg::FUNC_FREE: begin
				wr_addr = tgt_addr;
				wr_data = tgt_byte_q & ~tgt_mask;
				if (!in_range) begin
					res_status = bffa_pkg::ST_RANGE;
				end else if ((tgt_byte_q & tgt_mask) == '0) begin
					res_num    = idx_q;
					res_status = bffa_pkg::ST_FREE;
				end else begin
					res_num  = idx_q;
					wr_req   = 1'b1;
					res_free = free_cnt_q + bffa_pkg::CNT_W'(1);
				end
			end
			default: begin
				res_status = bffa_pkg::ST_OK;
			end
		endcase
	end

	assign wr_en    = exec_go && wr_req;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	// scan never reads past the clipped range
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= span_q))
		else $error("scan counter beyond range");

	// bitmap is only written when a result is produced
	a_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_EXEC) && out_free)
		else $error("bitmap write outside result step");

	// counted free entries fit in the range being reported
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> (free_cnt_q <= limit))
		else $error("free count exceeds range");

	// a found entry lies within the range
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && found_q |-> (found_num != '0) && (found_num <= limit))
		else $error("found entry outside range");

	// a new result only comes out of the decision step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_EXEC))
		else $error("result raised outside decision step");
`endif

endmodule

`default_nettype wire
